/* rtl/core/ceh_pkg.sv */
// ----------------------------------------------------------------------------
// ceh_pkg
// Shared types and constants of the calibrated energy histogrammer.
// ----------------------------------------------------------------------------
package ceh_pkg;

    localparam int CHAN_W            = 16;
    localparam int CFG_W             = 16;
    localparam int COUNT_W           = 32;
    localparam int DET_W             = 2;
    localparam int RBIN_W            = 7;
    localparam int ACT_W             = 2;
    localparam int CHANNELS_PER_ITEM = 4;

    localparam int FRAC_BITS = 18;
    localparam int E18_W     = 38;

    // lane pipeline depth, input request to histogram update
    localparam int LANE_LAT = 6;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int CRED_W    = 4;

    localparam int S_TDATA_W = 80;
    localparam int S_PAD_W   = S_TDATA_W - CHANNELS_PER_ITEM * CHAN_W - DET_W - RBIN_W;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - COUNT_W - DET_W - RBIN_W;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_BASE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BASE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT   = 4'd8;

    localparam logic [CFG_W-1:0] SLOPE_RESET [CHANNELS_PER_ITEM] =
        '{16'd17203, 16'd17203, 16'd15565, 16'd15565};
    localparam logic [CFG_W-1:0] OFFSET_RESET [CHANNELS_PER_ITEM] =
        '{16'hFEC0, 16'd320, 16'hFEC0, 16'd320};

    typedef enum logic [ACT_W-1:0] {
        ACT_EVENT      = 2'd0,
        ACT_READ       = 2'd1,
        ACT_READ_CLEAR = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_EVENT = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAN_W-1:0] chan;
        logic [RBIN_W-1:0] rbin;
    } lane_req_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
    } lane_rsp_t;

    typedef struct packed {
        logic              valid;
        logic [DET_W-1:0]  det;
        logic [RBIN_W-1:0] bin;
    } read_meta_t;

    typedef struct packed {
        logic [RBIN_W-1:0]  bin;
        logic [DET_W-1:0]   det;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

/* rtl/core/ceh_ram.sv */
// ----------------------------------------------------------------------------
// ceh_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module ceh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ceh_lane.sv */
// ----------------------------------------------------------------------------
// ceh_lane
// One detector lane: calibration, bin search by reciprocal, and a
// read-modify-write of that detector's histogram with one-deep forwarding.
// ----------------------------------------------------------------------------
module ceh_lane #(
    parameter int NUM_BINS  = 100,
    parameter int RANGE_MAX = 1000
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  ceh_pkg::lane_req_t                             req,
    input  logic [ceh_pkg::CFG_W-1:0]                      slope,
    input  logic [ceh_pkg::CFG_W-1:0]                      offset,
    input  logic                                           clr_en,
    input  logic [((NUM_BINS > 1) ? $clog2(NUM_BINS) : 1)-1:0] clr_addr,
    output ceh_pkg::lane_rsp_t                             rsp
);

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int E_W   = $clog2(RANGE_MAX) + ceh_pkg::FRAC_BITS;
    localparam int NB_W  = $clog2(NUM_BINS + 1);
    localparam int Y_W   = $clog2(NUM_BINS * RANGE_MAX + 1);
    localparam int PY_W  = E_W + NB_W;
    localparam int PR_W  = 2 * Y_W + 1;
    localparam logic [ceh_pkg::E18_W-1:0] LIMIT =
        ceh_pkg::E18_W'(RANGE_MAX) << ceh_pkg::FRAC_BITS;
    localparam logic [Y_W:0] RECIP = (Y_W + 1)'((64'd1 << Y_W) / RANGE_MAX);

    ceh_pkg::op_t                 s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    ceh_pkg::op_t                 s5_op_reg, s6_op_reg, s2_op_next;
    logic [BIN_W-1:0]             s1_addr_reg, s2_addr_reg, s3_addr_reg, s4_addr_reg;
    logic [BIN_W-1:0]             s5_addr_reg, s6_addr_reg, s5_addr_next;
    logic [31:0]                  s1_prod_reg, s1_prod_next;
    logic [ceh_pkg::E18_W-1:0]    e18;
    logic [E_W-1:0]               s2_e_reg;
    logic [PY_W-1:0]              py;
    logic [Y_W-1:0]               s3_y_reg, s4_y_reg, s3_y_next;
    logic [PR_W-1:0]              pr;
    logic [BIN_W-1:0]             s4_est_reg, s4_est_next, bin;
    logic [Y_W:0]                 em, rem;

    logic                         we;
    logic [BIN_W-1:0]             waddr;
    logic [ceh_pkg::COUNT_W-1:0]  wdata, rdata, cur, inc;
    logic                         last_valid_reg;
    logic [BIN_W-1:0]             last_addr_reg;
    logic [ceh_pkg::COUNT_W-1:0]  last_data_reg;

    // stage 1: gain multiply
    assign s1_prod_next = {16'd0, req.chan} * {16'd0, slope};

    // stage 2: offset and range check
    assign e18 = {2'b00, s1_prod_reg, 4'b0000}
               + {{8{offset[ceh_pkg::CFG_W-1]}}, offset, 14'd0};
    assign s2_op_next = (s1_op_reg == ceh_pkg::OP_EVENT && !(e18 < LIMIT))
                      ? ceh_pkg::OP_IDLE : s1_op_reg;

    // stage 3: scale by bin count, drop fraction
    assign py        = PY_W'(s2_e_reg) * PY_W'(NUM_BINS);
    assign s3_y_next = py[ceh_pkg::FRAC_BITS +: Y_W];

    // stage 4: reciprocal estimate, low by at most one
    assign pr          = PR_W'(s3_y_reg) * PR_W'(RECIP);
    assign s4_est_next = pr[Y_W +: BIN_W];

    // stage 5: correction
    assign em  = (Y_W + 1)'(s4_est_reg) * (Y_W + 1)'(RANGE_MAX);
    assign rem = {1'b0, s4_y_reg} - em;
    assign bin = (rem >= (Y_W + 1)'(RANGE_MAX)) ? s4_est_reg + BIN_W'(1) : s4_est_reg;
    assign s5_addr_next = (s4_op_reg == ceh_pkg::OP_EVENT) ? bin : s4_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg <= ceh_pkg::OP_IDLE;
            s2_op_reg <= ceh_pkg::OP_IDLE;
            s3_op_reg <= ceh_pkg::OP_IDLE;
            s4_op_reg <= ceh_pkg::OP_IDLE;
            s5_op_reg <= ceh_pkg::OP_IDLE;
            s6_op_reg <= ceh_pkg::OP_IDLE;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            s1_op_reg <= req.op;
            s2_op_reg <= s2_op_next;
            s3_op_reg <= s2_op_reg;
            s4_op_reg <= s3_op_reg;
            s5_op_reg <= s4_op_reg;
            s6_op_reg <= s5_op_reg;
            last_valid_reg <= we;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg   <= s1_prod_next;
        s1_addr_reg   <= BIN_W'(req.rbin);
        s2_e_reg      <= e18[E_W-1:0];
        s2_addr_reg   <= s1_addr_reg;
        s3_y_reg      <= s3_y_next;
        s3_addr_reg   <= s2_addr_reg;
        s4_y_reg      <= s3_y_reg;
        s4_est_reg    <= s4_est_next;
        s4_addr_reg   <= s3_addr_reg;
        s5_addr_reg   <= s5_addr_next;
        s6_addr_reg   <= s5_addr_reg;
        last_addr_reg <= waddr;
        last_data_reg <= wdata;
    end

    // stage 6: update, with the previous cycle's write forwarded
    assign cur = (last_valid_reg && last_addr_reg == s6_addr_reg) ? last_data_reg : rdata;
    assign inc = (&cur) ? cur : cur + ceh_pkg::COUNT_W'(1);

    always_comb
    begin
        we    = clr_en || s6_op_reg == ceh_pkg::OP_EVENT || s6_op_reg == ceh_pkg::OP_CLEAR;
        waddr = clr_en ? clr_addr : s6_addr_reg;
        wdata = (!clr_en && s6_op_reg == ceh_pkg::OP_EVENT) ? inc : '0;
    end

    assign rsp.hit   = (s6_op_reg == ceh_pkg::OP_READ) || (s6_op_reg == ceh_pkg::OP_CLEAR);
    assign rsp.count = rsp.hit ? cur : '0;

    ceh_ram #(
        .WIDTH (ceh_pkg::COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (s5_addr_reg),
        .rdata (rdata)
    );

endmodule

/* rtl/core/ceh_merge.sv */
// ----------------------------------------------------------------------------
// ceh_merge
// Aligns read requests with the lane answers, merges them and queues the
// results for the output stream.
// ----------------------------------------------------------------------------
module ceh_merge #(
    parameter int NUM_LANES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ceh_pkg::read_meta_t meta_in,
    input  ceh_pkg::lane_rsp_t  rsp [NUM_LANES],
    output logic                out_valid,
    input  logic                out_ready,
    output ceh_pkg::result_t    out_item
);

    ceh_pkg::read_meta_t               dly_reg [ceh_pkg::LANE_LAT];
    ceh_pkg::result_t                  fifo_reg [ceh_pkg::OUT_DEPTH];
    logic [ceh_pkg::OUT_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [ceh_pkg::CRED_W-1:0]        occ_reg, occ_next;
    logic [ceh_pkg::COUNT_W-1:0]       merged;
    ceh_pkg::read_meta_t               tail;
    logic                              push, pop;

    always_comb
    begin
        merged = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            merged = merged | rsp[i].count;
        end
    end

    assign tail = dly_reg[ceh_pkg::LANE_LAT-1];
    assign push = tail.valid;
    assign pop  = out_valid && out_ready;
    assign occ_next = occ_reg + ceh_pkg::CRED_W'(push) - ceh_pkg::CRED_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ceh_pkg::LANE_LAT; i++)
            begin
                dly_reg[i] <= '0;
            end
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            dly_reg[0] <= meta_in;
            for (int i = 1; i < ceh_pkg::LANE_LAT; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + ceh_pkg::OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ceh_pkg::OUT_PTR_W'(1);
            end
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{bin: tail.bin, det: tail.det, count: merged};
        end
    end

    assign out_valid = (occ_reg != '0);
    assign out_item  = fifo_reg[rd_ptr_reg];

endmodule

/* rtl/core/calibrated_energy_histogrammer_core.sv */
// ----------------------------------------------------------------------------
// calibrated_energy_histogrammer_core
// Four-detector multichannel analyzer with linear calibration per detector.
// ----------------------------------------------------------------------------
// After reset the histograms are cleared in a pass over every bin, during
// which s_tready stays low (configuration writes are taken). Afterwards one
// request is taken per clock while s_tready is high: each detector has its
// own six-stage lane (gain multiply, offset and range check, bin scaling,
// reciprocal estimate, correction, histogram read-modify-write), so
// back-to-back events on the same bin are counted without stalls. A read
// result passes through the lane stages and then the output queue before it
// is presented on the master side; up to eight reads may be outstanding, in
// the lanes or waiting on the master side, and s_tready is low while
// eight are.
// ----------------------------------------------------------------------------
module calibrated_energy_histogrammer_core #(
    parameter int NUM_DETECTORS = 4,
    parameter int NUM_BINS      = 100,
    parameter int RANGE_MAX     = 1000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // chan_a[15:0] chan_b[31:16] chan_c[47:32] chan_d[63:48]
    // read_detector[65:64] read_bin[72:66], zero above
    input  logic [ceh_pkg::S_TDATA_W-1:0]     s_tdata,
    // action[1:0]
    input  logic [ceh_pkg::ACT_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bin_count[31:0] count_detector[33:32] count_bin[40:34], zero above
    output logic [ceh_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ceh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ceh_pkg::CFG_W-1:0]         cfg_data
);

    localparam int NUM_LANES = (NUM_DETECTORS < ceh_pkg::CHANNELS_PER_ITEM)
                             ? NUM_DETECTORS : ceh_pkg::CHANNELS_PER_ITEM;
    localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [ceh_pkg::CFG_W-1:0]  slope_reg  [ceh_pkg::CHANNELS_PER_ITEM];
    logic [ceh_pkg::CFG_W-1:0]  offset_reg [ceh_pkg::CHANNELS_PER_ITEM];
    logic                       clr_busy_reg;
    logic [BIN_W-1:0]           clr_addr_reg;
    logic [ceh_pkg::CRED_W-1:0] cred_reg, cred_next;

    logic                       accept, is_event, is_read, is_clear, read_ok;
    logic [ceh_pkg::DET_W-1:0]  rd_det;
    logic [ceh_pkg::RBIN_W-1:0] rd_bin;
    ceh_pkg::lane_req_t         lane_req [NUM_LANES];
    ceh_pkg::lane_rsp_t         lane_rsp [NUM_LANES];
    ceh_pkg::read_meta_t        meta;
    ceh_pkg::result_t           out_item;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ceh_pkg::CHANNELS_PER_ITEM; i++)
            begin
                slope_reg[i]  <= ceh_pkg::SLOPE_RESET[i];
                offset_reg[i] <= ceh_pkg::OFFSET_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index < ceh_pkg::CFG_OFFSET_BASE)
            begin
                slope_reg[cfg_index[1:0]] <= cfg_data;
            end
            else if (cfg_index < ceh_pkg::CFG_REG_COUNT)
            begin
                offset_reg[cfg_index[1:0]] <= cfg_data;
            end
        end
    end

    // request decode
    assign accept = s_tvalid && s_tready;
    assign rd_det = s_tdata[64 +: ceh_pkg::DET_W];
    assign rd_bin = s_tdata[66 +: ceh_pkg::RBIN_W];
    assign read_ok = (int'(rd_det) < NUM_LANES) && (int'(rd_bin) < NUM_BINS);

    always_comb
    begin
        is_event = 1'b0;
        is_read  = 1'b0;
        is_clear = 1'b0;
        unique case (s_tuser)
            ceh_pkg::ACT_EVENT:      is_event = accept;
            ceh_pkg::ACT_READ:       is_read  = accept;
            ceh_pkg::ACT_READ_CLEAR:
            begin
                is_read  = accept;
                is_clear = accept;
            end
            default:
            begin
                is_event = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lane_req[i].chan = s_tdata[i*ceh_pkg::CHAN_W +: ceh_pkg::CHAN_W];
            lane_req[i].rbin = rd_bin;
            if (is_event)
            begin
                lane_req[i].op = ceh_pkg::OP_EVENT;
            end
            else if (is_read && read_ok && rd_det == ceh_pkg::DET_W'(i))
            begin
                lane_req[i].op = is_clear ? ceh_pkg::OP_CLEAR : ceh_pkg::OP_READ;
            end
            else
            begin
                lane_req[i].op = ceh_pkg::OP_IDLE;
            end
        end
    end

    assign meta = '{valid: is_read, det: rd_det, bin: rd_bin};

    // clearing pass and result credits
    assign cred_next = cred_reg + ceh_pkg::CRED_W'(is_read)
                     - ceh_pkg::CRED_W'(m_tvalid && m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            cred_reg     <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + BIN_W'(1);
                if (clr_addr_reg == BIN_W'(NUM_BINS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            cred_reg <= cred_next;
        end
    end

    assign s_tready = !clr_busy_reg && (cred_reg < ceh_pkg::CRED_W'(ceh_pkg::OUT_DEPTH));

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        ceh_lane #(
            .NUM_BINS  (NUM_BINS),
            .RANGE_MAX (RANGE_MAX)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (lane_req[g]),
            .slope    (slope_reg[g]),
            .offset   (offset_reg[g]),
            .clr_en   (clr_busy_reg),
            .clr_addr (clr_addr_reg),
            .rsp      (lane_rsp[g])
        );
    end

    ceh_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .meta_in   (meta),
        .rsp       (lane_rsp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {{ceh_pkg::M_PAD_W{1'b0}}, out_item.bin, out_item.det, out_item.count};

endmodule

/* rtl/core/ceh_checker.sv */
// ----------------------------------------------------------------------------
// ceh_checker
// Port-level checks of the histogrammer core, bound to the top level.
// ----------------------------------------------------------------------------
module ceh_checker #(
    parameter int NUM_BINS = 100
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ceh_pkg::M_TDATA_W-1:0] m_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // clearing pass blocks requests right after reset
    a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("request taken before histogram clear");

    // out-of-range bin always reads zero
    a_bad_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (int'(m_tdata[40:34]) >= NUM_BINS) |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero count for bin beyond histogram");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[ceh_pkg::M_TDATA_W-1:41] == '0)
        else $error("padding bits set in result");

endmodule

bind calibrated_energy_histogrammer_core ceh_checker #(
    .NUM_BINS (NUM_BINS)
) u_ceh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
